/* hdl/nbds_pkg.sv */
// Shared types, widths and codes for the direct-sum n-body step unit.
// No dependencies.
package nbds_pkg;

  localparam int MAX_PARTICLES_DEF = 512;
  localparam int IDX_W   = 9;
  localparam int COUNT_W = 10;
  localparam int COORD_W = 32;
  localparam int MASS_W  = 24;
  localparam int GAIN_W  = 32;
  localparam int CFG_W   = 32;
  localparam int NUM_W   = 101;
  localparam int DEN_W   = 96;
  localparam int Q_W     = 41;
  localparam int TERM_W  = Q_W + 1;
  localparam int STEP_W  = 7;

  localparam logic [Q_W-1:0] TERM_LIMIT = {1'b1, {(Q_W-1){1'b0}}};

  localparam logic [COUNT_W-1:0] ACTIVE_RESET = COUNT_W'(512);
  localparam logic [GAIN_W-1:0]  GAIN_RESET   = GAIN_W'(65536);

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_STEP = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_GAIN   = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [TERM_W-1:0]  term_t;

  typedef struct packed {
    logic done;
    logic skip;
  } fu_stat_t;

endpackage

/* hdl/nbody_direct_sum_step_unit.sv */
// A timestep runs the force unit once per ordered pair of distinct active
// particles; the pair time is set by the force unit's divider and square root.
// Particle state sits in position, velocity and mass memories with
// registered reads; no clearing pass follows reset.
//
// Top level of the direct-sum n-body step unit.
// Depends on nbds_pkg and nbds_force_unit.
module nbody_direct_sum_step_unit #(
  parameter int MAX_PARTICLES = nbds_pkg::MAX_PARTICLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [nbds_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [nbds_pkg::IDX_W-1:0]    in_particle_index,
  input  nbds_pkg::coord_t              in_load_pos_x,
  input  nbds_pkg::coord_t              in_load_pos_y,
  input  nbds_pkg::coord_t              in_load_pos_z,
  input  nbds_pkg::coord_t              in_load_vel_x,
  input  nbds_pkg::coord_t              in_load_vel_y,
  input  nbds_pkg::coord_t              in_load_vel_z,
  input  logic [nbds_pkg::MASS_W-1:0]   in_load_mass,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_result_kind,
  output logic [nbds_pkg::IDX_W-1:0]    out_result_index,
  output nbds_pkg::coord_t              out_pos_x,
  output nbds_pkg::coord_t              out_pos_y,
  output nbds_pkg::coord_t              out_pos_z
);

  localparam int AW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW  = $clog2(MAX_PARTICLES + 1);
  localparam int XW  = ((AW > nbds_pkg::IDX_W) ? AW : nbds_pkg::IDX_W) + 1;
  localparam int NCW = ((CW > nbds_pkg::COUNT_W) ? CW : nbds_pkg::COUNT_W) + 1;
  localparam int ACC_W = nbds_pkg::TERM_W + $clog2(MAX_PARTICLES);
  localparam int SUM_W = ACC_W + 1;
  localparam int VW  = 3 * nbds_pkg::COORD_W;
  localparam int MW  = nbds_pkg::MASS_W;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2**31 - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_RDOUT  = 11'b000_0000_0010,
    S_ROW    = 11'b000_0000_0100,
    S_ROWL   = 11'b000_0000_1000,
    S_PAIR   = 11'b000_0001_0000,
    S_PSTART = 11'b000_0010_0000,
    S_FWAIT  = 11'b000_0100_0000,
    S_VWR    = 11'b000_1000_0000,
    S_PRD    = 11'b001_0000_0000,
    S_PWR    = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  function automatic nbds_pkg::coord_t sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = v;
    if (v > SAT_HI) t = SAT_HI;
    if (v < SAT_LO) t = SAT_LO;
    return nbds_pkg::coord_t'(t[nbds_pkg::COORD_W-1:0]);
  endfunction

  state_t state_r, state_nxt;
  logic [nbds_pkg::COUNT_W-1:0] active_r;
  logic [nbds_pkg::GAIN_W-1:0]  gain_r;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, n_r, n_nxt;
  nbds_pkg::coord_t [2:0] pi_r, pi_nxt, vi_r, vi_nxt;
  logic signed [ACC_W-1:0] acc_r [3];
  logic signed [ACC_W-1:0] acc_nxt [3];
  logic rd_zero_r, rd_zero_nxt;
  logic [nbds_pkg::IDX_W-1:0] rd_idx_r, rd_idx_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_kind_r, out_kind_nxt;
  logic [nbds_pkg::IDX_W-1:0] out_idx_r, out_idx_nxt;
  nbds_pkg::coord_t [2:0] out_pos_r, out_pos_nxt;

  logic [VW-1:0] pos_mem [MAX_PARTICLES];
  logic [VW-1:0] vel_mem [MAX_PARTICLES];
  logic [MW-1:0] mass_mem [MAX_PARTICLES];
  logic [VW-1:0] pos_rd_r, vel_rd_r;
  logic [MW-1:0] mass_rd_r;
  logic pos_we, vel_we, mass_we, rd_en;
  logic [AW-1:0] pos_wa, vel_wa, rd_addr;
  logic [VW-1:0] pos_wd, vel_wd;

  logic accept;
  logic [XW-1:0] idx_x;
  logic idx_ok;
  logic [NCW-1:0] act_x;
  logic out_free;
  nbds_pkg::coord_t [2:0] pos_rd, vel_rd, vel_new, pos_new;

  logic fu_start;
  nbds_pkg::fu_stat_t fu_stat;
  nbds_pkg::term_t [2:0] fu_term;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign idx_x    = XW'(in_particle_index);
  assign idx_ok   = idx_x < XW'(MAX_PARTICLES);
  assign act_x    = NCW'(active_r);
  assign out_free = !out_valid_r || !out_stall;
  assign pos_rd   = pos_rd_r;
  assign vel_rd   = vel_rd_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vel_new[k] = sat32(SUM_W'(vi_r[k]) + SUM_W'(acc_r[k]));
      pos_new[k] = sat32(SUM_W'(pos_rd[k]) + SUM_W'(vel_rd[k]));
    end
  end

  nbds_force_unit u_force (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fu_start),
    .pi    (pi_r),
    .pj    (pos_rd_r),
    .mass  (mass_rd_r),
    .gain  (gain_r),
    .stat  (fu_stat),
    .term  (fu_term)
  );

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    pi_nxt        = pi_r;
    vi_nxt        = vi_r;
    rd_zero_nxt   = rd_zero_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_pos_nxt   = out_pos_r;
    for (int k = 0; k < 3; k++) begin
      acc_nxt[k] = acc_r[k];
    end
    pos_we   = 1'b0;
    vel_we   = 1'b0;
    mass_we  = 1'b0;
    pos_wa   = idx_x[AW-1:0];
    vel_wa   = idx_x[AW-1:0];
    pos_wd   = {in_load_pos_z, in_load_pos_y, in_load_pos_x};
    vel_wd   = {in_load_vel_z, in_load_vel_y, in_load_vel_x};
    rd_en    = 1'b0;
    rd_addr  = idx_x[AW-1:0];
    fu_start = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            nbds_pkg::MODE_LOAD: begin
              pos_we  = idx_ok;
              vel_we  = idx_ok;
              mass_we = idx_ok;
            end
            nbds_pkg::MODE_STEP: begin
              n_nxt     = (act_x > NCW'(MAX_PARTICLES)) ? CW'(MAX_PARTICLES)
                                                       : act_x[CW-1:0];
              i_nxt     = '0;
              state_nxt = S_ROW;
            end
            nbds_pkg::MODE_READ: begin
              rd_en       = idx_ok;
              rd_zero_nxt = !idx_ok;
              rd_idx_nxt  = in_particle_index;
              state_nxt   = S_RDOUT;
            end
            default: begin
            end
          endcase
        end
      end
      S_RDOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = nbds_pkg::KIND_READ;
          out_idx_nxt   = rd_idx_r;
          out_pos_nxt   = rd_zero_r ? '0 : pos_rd;
          state_nxt     = S_IDLE;
        end
      end
      S_ROW: begin
        if (i_r == n_r) begin
          i_nxt     = '0;
          state_nxt = S_PRD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = i_r[AW-1:0];
          j_nxt     = '0;
          state_nxt = S_ROWL;
        end
      end
      S_ROWL: begin
        pi_nxt = pos_rd;
        vi_nxt = vel_rd;
        for (int k = 0; k < 3; k++) begin
          acc_nxt[k] = '0;
        end
        state_nxt = S_PAIR;
      end
      S_PAIR: begin
        if (j_r == n_r) begin
          state_nxt = S_VWR;
        end else if (j_r == i_r) begin
          j_nxt = j_r + 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = j_r[AW-1:0];
          state_nxt = S_PSTART;
        end
      end
      S_PSTART: begin
        fu_start  = 1'b1;
        state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        if (fu_stat.done) begin
          if (!fu_stat.skip) begin
            for (int k = 0; k < 3; k++) begin
              acc_nxt[k] = acc_r[k] + ACC_W'(fu_term[k]);
            end
          end
          j_nxt     = j_r + 1'b1;
          state_nxt = S_PAIR;
        end
      end
      S_VWR: begin
        vel_we    = 1'b1;
        vel_wa    = i_r[AW-1:0];
        vel_wd    = vel_new;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_ROW;
      end
      S_PRD: begin
        if (i_r == n_r) begin
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = i_r[AW-1:0];
          state_nxt = S_PWR;
        end
      end
      S_PWR: begin
        pos_we    = 1'b1;
        pos_wa    = i_r[AW-1:0];
        pos_wd    = pos_new;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_PRD;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = nbds_pkg::KIND_DONE;
          out_idx_nxt   = '0;
          out_pos_nxt   = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    if (rd_en) begin
      pos_rd_r <= pos_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (vel_we) begin
      vel_mem[vel_wa] <= vel_wd;
    end
    if (rd_en) begin
      vel_rd_r <= vel_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mass_we) begin
      mass_mem[pos_wa] <= in_load_mass;
    end
    if (rd_en) begin
      mass_rd_r <= mass_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= nbds_pkg::ACTIVE_RESET;
      gain_r   <= nbds_pkg::GAIN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        nbds_pkg::REG_ACTIVE: active_r <= cfg_wr_data[nbds_pkg::COUNT_W-1:0];
        nbds_pkg::REG_GAIN:   gain_r   <= cfg_wr_data[nbds_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    n_r        <= n_nxt;
    pi_r       <= pi_nxt;
    vi_r       <= vi_nxt;
    rd_zero_r  <= rd_zero_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_pos_r  <= out_pos_nxt;
    for (int k = 0; k < 3; k++) begin
      acc_r[k] <= acc_nxt[k];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_result_index = out_idx_r;
  assign out_pos_x        = out_pos_r[0];
  assign out_pos_y        = out_pos_r[1];
  assign out_pos_z        = out_pos_r[2];

endmodule

/* hdl/nbds_force_unit.sv */
// Pair force unit: pull of one particle on another along three axes.
// Shared 32x32 multiplier, bit-serial square root, three radix-2 dividers.
// Depends on nbds_pkg.
module nbds_force_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  nbds_pkg::coord_t [2:0]       pi,
  input  nbds_pkg::coord_t [2:0]       pj,
  input  logic [nbds_pkg::MASS_W-1:0]  mass,
  input  logic [nbds_pkg::GAIN_W-1:0]  gain,
  output nbds_pkg::fu_stat_t           stat,
  output nbds_pkg::term_t [2:0]        term
);

  typedef enum logic [7:0] {
    F_IDLE = 8'b0000_0001,
    F_SQ   = 8'b0000_0010,
    F_CHK  = 8'b0000_0100,
    F_SQRT = 8'b0000_1000,
    F_DEN  = 8'b0001_0000,
    F_NUM  = 8'b0010_0000,
    F_DIV  = 8'b0100_0000,
    F_FIN  = 8'b1000_0000
  } fstate_t;

  localparam int NW = nbds_pkg::NUM_W;
  localparam int DW = nbds_pkg::DEN_W;
  localparam int QW = nbds_pkg::Q_W;
  localparam int SW = nbds_pkg::STEP_W;

  fstate_t state_r, state_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic skip_r, skip_nxt;

  logic [31:0] mag_r [3];
  logic [31:0] mag_nxt [3];
  logic [2:0] neg_r, neg_nxt;
  logic [nbds_pkg::MASS_W-1:0] mass_r, mass_nxt;
  logic [63:0] s_r, s_nxt, sh_r, sh_nxt;
  logic [33:0] srem_r, srem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [55:0] w_r, w_nxt;
  logic [NW-1:0] num_r [3];
  logic [NW-1:0] num_nxt [3];
  logic [DW-1:0] rem_r [3];
  logic [DW-1:0] rem_nxt [3];
  logic [QW-1:0] q_r [3];
  logic [QW-1:0] q_nxt [3];
  logic [2:0] ovf_r, ovf_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [1:0] axis;
  logic [35:0] sq_sh, sq_trial;
  logic [DW:0] dv_sh [3];
  logic dv_ge [3];
  logic signed [33:0] diff [3];
  logic [QW-1:0] qlim [3];

  assign mul_p = mul_a * mul_b;
  assign axis  = cnt_r[2:1];

  assign sq_sh    = {srem_r, sh_r[63:62]};
  assign sq_trial = {2'b00, root_r, 2'b01};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]  = 34'(pj[k]) - 34'(pi[k]);
      dv_sh[k] = {rem_r[k], num_r[k][NW-1]};
      dv_ge[k] = dv_sh[k] >= {1'b0, den_r};
      qlim[k]  = (ovf_r[k] || q_r[k] > nbds_pkg::TERM_LIMIT) ? nbds_pkg::TERM_LIMIT : q_r[k];
      term[k]  = neg_r[k] ? -nbds_pkg::TERM_W'(qlim[k]) : nbds_pkg::TERM_W'(qlim[k]);
    end
  end

  assign stat.done = (state_r == F_FIN);
  assign stat.skip = skip_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    skip_nxt  = skip_r;
    neg_nxt   = neg_r;
    mass_nxt  = mass_r;
    s_nxt     = s_r;
    sh_nxt    = sh_r;
    srem_nxt  = srem_r;
    root_nxt  = root_r;
    den_nxt   = den_r;
    w_nxt     = w_r;
    ovf_nxt   = ovf_r;
    mul_a     = '0;
    mul_b     = '0;
    for (int k = 0; k < 3; k++) begin
      mag_nxt[k] = mag_r[k];
      num_nxt[k] = num_r[k];
      rem_nxt[k] = rem_r[k];
      q_nxt[k]   = q_r[k];
    end

    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          for (int k = 0; k < 3; k++) begin
            neg_nxt[k] = diff[k] < 0;
            mag_nxt[k] = diff[k] < 0 ? 32'(-diff[k]) : 32'(diff[k]);
          end
          mass_nxt  = mass;
          s_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = F_SQ;
        end
      end
      F_SQ: begin
        mul_a   = mag_r[cnt_r[1:0]];
        mul_b   = mag_r[cnt_r[1:0]];
        s_nxt   = s_r + {2'b00, mul_p[63:2]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SW'(2)) begin
          state_nxt = F_CHK;
        end
      end
      F_CHK: begin
        sh_nxt   = s_r;
        srem_nxt = '0;
        root_nxt = '0;
        cnt_nxt  = '0;
        skip_nxt = (s_r == '0);
        state_nxt = (s_r == '0) ? F_FIN : F_SQRT;
      end
      F_SQRT: begin
        sh_nxt = {sh_r[61:0], 2'b00};
        if (sq_sh >= sq_trial) begin
          srem_nxt = 34'(sq_sh - sq_trial);
          root_nxt = {root_r[30:0], 1'b1};
        end else begin
          srem_nxt = sq_sh[33:0];
          root_nxt = {root_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SW'(31)) begin
          cnt_nxt   = '0;
          state_nxt = F_DEN;
        end
      end
      F_DEN: begin
        cnt_nxt = cnt_r + 1'b1;
        case (cnt_r[1:0])
          2'd0: begin
            mul_a   = root_r;
            mul_b   = s_r[31:0];
            den_nxt = DW'(mul_p);
          end
          2'd1: begin
            mul_a   = root_r;
            mul_b   = s_r[63:32];
            den_nxt = den_r + {mul_p, 32'b0};
          end
          default: begin
            mul_a     = gain;
            mul_b     = {8'b0, mass_r};
            w_nxt     = mul_p[55:0];
            cnt_nxt   = '0;
            state_nxt = F_NUM;
          end
        endcase
      end
      F_NUM: begin
        mul_b   = mag_r[axis];
        cnt_nxt = cnt_r + 1'b1;
        if (!cnt_r[0]) begin
          mul_a         = w_r[31:0];
          num_nxt[axis] = NW'(mul_p);
        end else begin
          mul_a         = {8'b0, w_r[55:32]};
          num_nxt[axis] = (num_r[axis] + NW'({mul_p, 32'b0})) << 13;
        end
        if (cnt_r == SW'(5)) begin
          cnt_nxt = '0;
          for (int k = 0; k < 3; k++) begin
            rem_nxt[k] = '0;
            q_nxt[k]   = '0;
          end
          ovf_nxt   = '0;
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        for (int k = 0; k < 3; k++) begin
          rem_nxt[k] = dv_ge[k] ? DW'(dv_sh[k] - {1'b0, den_r}) : dv_sh[k][DW-1:0];
          num_nxt[k] = {num_r[k][NW-2:0], 1'b0};
          ovf_nxt[k] = ovf_r[k] | q_r[k][QW-1];
          q_nxt[k]   = {q_r[k][QW-2:0], dv_ge[k]};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SW'(NW - 1)) begin
          skip_nxt  = 1'b0;
          state_nxt = F_FIN;
        end
      end
      F_FIN: begin
        state_nxt = F_IDLE;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
      skip_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      skip_r  <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    mass_r <= mass_nxt;
    s_r    <= s_nxt;
    sh_r   <= sh_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
    den_r  <= den_nxt;
    w_r    <= w_nxt;
    ovf_r  <= ovf_nxt;
    for (int k = 0; k < 3; k++) begin
      mag_r[k] <= mag_nxt[k];
      num_r[k] <= num_nxt[k];
      rem_r[k] <= rem_nxt[k];
      q_r[k]   <= q_nxt[k];
    end
  end

endmodule
